>>> src/playback_rate_ramp_controller_top_defines.svh
// ---------------------------------------------------------------------------
// playback rate ramp controller assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PLAYBACK_RATE_RAMP_CONTROLLER_TOP_DEFINES_SVH
`define PLAYBACK_RATE_RAMP_CONTROLLER_TOP_DEFINES_SVH

// invariant that holds at every clock edge
`define PRRC_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PRRC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define PRRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/prrc_pkg.sv
// ---------------------------------------------------------------------------
// prrc_pkg
// Types, widths, operation codes and the control program of the rate ramp
// controller.
// ---------------------------------------------------------------------------
package prrc_pkg;

	// field widths
	localparam int RATE_W = 17;
	localparam int OUT_W  = 18;
	localparam int MS_W   = 16;
	localparam int GEAR_W = 4;
	localparam int PROD_W = OUT_W + MS_W;
	localparam int REM_W  = MS_W;
	localparam int DIV_STEPS = PROD_W;
	localparam int CNT_W  = $clog2(DIV_STEPS);
	localparam int OP_W   = 3;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
	localparam logic [OP_W-1:0] OP_REV_START = 3'd1;
	localparam logic [OP_W-1:0] OP_REV_STOP  = 3'd2;
	localparam logic [OP_W-1:0] OP_GEAR_UP   = 3'd3;
	localparam logic [OP_W-1:0] OP_GEAR_DOWN = 3'd4;

	// shift peak is base * 13 / 10
	localparam logic [MS_W-1:0] PEAK_MUL = 16'd13;
	localparam logic [MS_W-1:0] PEAK_DIV = 16'd10;

	// configuration register map
	localparam int CFG_ADDR_W = 4;
	localparam logic [1:0] REG_REV_TARGET = 2'd0;
	localparam logic [1:0] REG_REV_UP     = 2'd1;
	localparam logic [1:0] REG_REV_DOWN   = 2'd2;
	localparam logic [1:0] REG_TOP_GEAR   = 2'd3;

	typedef struct packed {
		logic [RATE_W-1:0] rev_target_rate;
		logic [MS_W-1:0]   rev_up_ms;
		logic [MS_W-1:0]   rev_down_ms;
		logic [GEAR_W-1:0] top_gear;
	} cfg_t;

	// datapath action of one control word
	typedef enum logic [2:0] {
		ACT_WAIT,
		ACT_EVAL,
		ACT_MUL,
		ACT_DIV,
		ACT_FIN,
		ACT_OUT
	} act_t;

	// jump condition of one control word
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_NO_ACCEPT,
		COND_NO_DIV,
		COND_DIV_MORE,
		COND_OUT_BUSY
	} cond_t;

	typedef logic [2:0] pc_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		pc_t   jump;
		pc_t   fall;
	} ucode_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic accept;
		logic need_div;
		logic div_more;
		logic out_busy;
	} seq_stat_t;

	// control program
	function automatic ucode_t ucode_at(input pc_t pc);
		ucode_t w;
		case (pc)
			3'd0:    w = '{ACT_WAIT, COND_NO_ACCEPT, 3'd0, 3'd1};
			3'd1:    w = '{ACT_EVAL, COND_NO_DIV,    3'd5, 3'd2};
			3'd2:    w = '{ACT_MUL,  COND_NEVER,     3'd0, 3'd3};
			3'd3:    w = '{ACT_DIV,  COND_DIV_MORE,  3'd3, 3'd4};
			3'd4:    w = '{ACT_FIN,  COND_NEVER,     3'd0, 3'd5};
			3'd5:    w = '{ACT_OUT,  COND_OUT_BUSY,  3'd5, 3'd0};
			default: w = '{ACT_WAIT, COND_NEVER,     3'd0, 3'd0};
		endcase
		return w;
	endfunction

endpackage

>>> src/prrc_in_if.sv
// ---------------------------------------------------------------------------
// prrc_in_if
// Event channel: operation code and throttle rate with valid/ready.
// ---------------------------------------------------------------------------
interface prrc_in_if import prrc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [RATE_W-1:0] throttle_rate;

	modport source (output valid, output operation, output throttle_rate, input ready);
	modport sink (input valid, input operation, input throttle_rate, output ready);
endinterface

>>> src/prrc_out_if.sv
// ---------------------------------------------------------------------------
// prrc_out_if
// Result channel: applied rate, update flag, gear and busy flag.
// ---------------------------------------------------------------------------
interface prrc_out_if import prrc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [OUT_W-1:0]  sample_rate;
	logic              rate_update;
	logic [GEAR_W-1:0] gear_now;
	logic              ramp_busy;

	modport source (output valid, output sample_rate, output rate_update,
		output gear_now, output ramp_busy, input ready);
	modport sink (input valid, input sample_rate, input rate_update,
		input gear_now, input ramp_busy, output ready);
endinterface

>>> src/prrc_cfg.sv
// ---------------------------------------------------------------------------
// prrc_cfg
// APB register file holding the ramp durations, target rate and gear limit.
// ---------------------------------------------------------------------------
module prrc_cfg import prrc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.rev_target_rate <= 17'd44100;
			cfg.rev_up_ms       <= 16'd1000;
			cfg.rev_down_ms     <= 16'd1000;
			cfg.top_gear        <= 4'd6;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_REV_TARGET: cfg.rev_target_rate <= pwdata[RATE_W-1:0];
				REG_REV_UP:     cfg.rev_up_ms       <= pwdata[MS_W-1:0];
				REG_REV_DOWN:   cfg.rev_down_ms     <= pwdata[MS_W-1:0];
				REG_TOP_GEAR:   cfg.top_gear        <= pwdata[GEAR_W-1:0];
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_REV_TARGET: prdata = 32'(cfg.rev_target_rate);
			REG_REV_UP:     prdata = 32'(cfg.rev_up_ms);
			REG_REV_DOWN:   prdata = 32'(cfg.rev_down_ms);
			REG_TOP_GEAR:   prdata = 32'(cfg.top_gear);
		endcase
	end

endmodule

>>> src/prrc_seq.sv
// ---------------------------------------------------------------------------
// prrc_seq
// Step counter over the control program with conditional jumps.
// ---------------------------------------------------------------------------
module prrc_seq import prrc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  seq_stat_t stat,
	output ucode_t    ctrl
);

	pc_t  pc_q;
	pc_t  pc_d;
	logic take;

	assign ctrl = ucode_at(pc_q);

	// jump condition
	always_comb begin
		case (ctrl.cond)
			COND_NEVER:     take = 1'b0;
			COND_NO_ACCEPT: take = !stat.accept;
			COND_NO_DIV:    take = !stat.need_div;
			COND_DIV_MORE:  take = stat.div_more;
			COND_OUT_BUSY:  take = stat.out_busy;
			default:        take = 1'b0;
		endcase
		pc_d = take ? ctrl.jump : ctrl.fall;
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

>>> src/playback_rate_ramp_controller_top.sv
// ---------------------------------------------------------------------------
// playback_rate_ramp_controller_top
// Playback rate envelope from rev, gear and 1 ms tick events.
// ---------------------------------------------------------------------------
// Each event transaction yields exactly one result transaction. Items are
// handled one at a time by a small control program: a rev start, rev stop,
// refused gear request or a tick that applies a fixed rate goes through the
// accept, evaluate and present steps; a tick that interpolates a ramp and an
// accepted gear change add multiply, the 34-step restoring divider that forms
// (to - from) * elapsed / duration and base * 13 / 10, and finish. A new event
// is taken while the previous result still waits in the output register; the
// program only stalls at the present step when that register is still full.
`include "playback_rate_ramp_controller_top_defines.svh"

module playback_rate_ramp_controller_top import prrc_pkg::*; #(
	parameter int SHIFT_UP_MS   = 150,
	parameter int SHIFT_DOWN_MS = 200
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	prrc_in_if.sink               item,
	prrc_out_if.source            result
);

	localparam logic [MS_W-1:0] SH_UP   = MS_W'(SHIFT_UP_MS);
	localparam logic [MS_W-1:0] SH_DOWN = MS_W'(SHIFT_DOWN_MS);

	cfg_t      cfg;
	ucode_t    ctrl;
	seq_stat_t stat;

	// architectural state
	logic              rev_active_q;
	logic              rev_falling_q;
	logic [MS_W-1:0]   rev_elapsed_q;
	logic [RATE_W-1:0] rev_base_q;
	logic              shift_active_q;
	logic              shift_second_q;
	logic [MS_W-1:0]   shift_elapsed_q;
	logic [RATE_W-1:0] shift_base_q;
	logic [OUT_W-1:0]  shift_peak_q;
	logic [GEAR_W-1:0] gear_q;

	// working registers
	logic [OP_W-1:0]   op_q;
	logic [RATE_W-1:0] thr_q;
	logic [OUT_W-1:0]  rate_q;
	logic              upd_q;
	logic              peak_mode_q;
	logic [OUT_W-1:0]  from_q;
	logic [OUT_W-1:0]  mag_q;
	logic              neg_q;
	logic [MS_W-1:0]   mul_b_q;
	logic [MS_W-1:0]   div_d_q;
	logic [PROD_W-1:0] quo_q;
	logic [REM_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;

	// output register
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_rate_q;
	logic              out_upd_q;
	logic [GEAR_W-1:0] out_gear_q;
	logic              out_busy_flag_q;

	// evaluation results
	logic              ev_rev_active;
	logic              ev_rev_falling;
	logic [MS_W-1:0]   ev_rev_elapsed;
	logic [RATE_W-1:0] ev_rev_base;
	logic              ev_shift_active;
	logic              ev_shift_second;
	logic [MS_W-1:0]   ev_shift_elapsed;
	logic [RATE_W-1:0] ev_shift_base;
	logic [GEAR_W-1:0] ev_gear;
	logic [OUT_W-1:0]  ev_rate;
	logic              ev_upd;
	logic              ev_div;
	logic              ev_peak;
	logic [OUT_W-1:0]  ev_from;
	logic [OUT_W-1:0]  ev_to;
	logic [MS_W-1:0]   ev_mul_b;
	logic [MS_W-1:0]   ev_d;

	logic [MS_W-1:0]   rev_e;
	logic [MS_W-1:0]   sh_e;
	logic              shift_ok;
	logic [REM_W:0]    trial;
	logic              trial_ge;
	logic              out_busy;

	prrc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	prrc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// handshake and sequencer status
	assign item.ready    = (ctrl.act == ACT_WAIT);
	assign out_busy      = out_valid_q && !result.ready;
	assign stat.accept   = item.valid && item.ready;
	assign stat.need_div = ev_div;
	assign stat.div_more = (cnt_q != CNT_W'(DIV_STEPS - 1));
	assign stat.out_busy = out_busy;

	// elapsed counters advance and saturate on a tick
	always_comb begin
		rev_e = rev_elapsed_q;
		if ((rev_active_q || rev_falling_q) && (rev_elapsed_q != '1)) begin
			rev_e = rev_elapsed_q + 1'b1;
		end
		sh_e = shift_elapsed_q;
		if (shift_active_q && (shift_elapsed_q != '1)) begin
			sh_e = shift_elapsed_q + 1'b1;
		end
	end

	assign shift_ok = !shift_active_q && !rev_active_q;

	// evaluate one event against the current state
	always_comb begin
		ev_rev_active    = rev_active_q;
		ev_rev_falling   = rev_falling_q;
		ev_rev_elapsed   = rev_elapsed_q;
		ev_rev_base      = rev_base_q;
		ev_shift_active  = shift_active_q;
		ev_shift_second  = shift_second_q;
		ev_shift_elapsed = shift_elapsed_q;
		ev_shift_base    = shift_base_q;
		ev_gear          = gear_q;
		ev_rate          = '0;
		ev_upd           = 1'b0;
		ev_div           = 1'b0;
		ev_peak          = 1'b0;
		ev_from          = '0;
		ev_to            = '0;
		ev_mul_b         = '0;
		ev_d             = '0;
		case (op_q)
			OP_TICK: begin
				ev_rev_elapsed   = rev_e;
				ev_shift_elapsed = sh_e;
				if (rev_active_q) begin
					ev_upd = 1'b1;
					if (rev_e >= cfg.rev_up_ms) begin
						ev_rate = OUT_W'(cfg.rev_target_rate);
					end else begin
						ev_div   = 1'b1;
						ev_from  = OUT_W'(rev_base_q);
						ev_to    = OUT_W'(cfg.rev_target_rate);
						ev_mul_b = rev_e;
						ev_d     = cfg.rev_up_ms;
					end
				end else if (rev_falling_q) begin
					ev_upd = 1'b1;
					if (rev_e < cfg.rev_down_ms) begin
						ev_div   = 1'b1;
						ev_from  = OUT_W'(cfg.rev_target_rate);
						ev_to    = OUT_W'(rev_base_q);
						ev_mul_b = rev_e;
						ev_d     = cfg.rev_down_ms;
					end else begin
						ev_rate        = OUT_W'(rev_base_q);
						ev_rev_falling = 1'b0;
					end
				end else if (shift_active_q) begin
					ev_upd = 1'b1;
					if (!shift_second_q) begin
						if (sh_e < SH_UP) begin
							ev_div   = 1'b1;
							ev_from  = OUT_W'(shift_base_q);
							ev_to    = shift_peak_q;
							ev_mul_b = sh_e;
							ev_d     = SH_UP;
						end else begin
							ev_shift_second  = 1'b1;
							ev_shift_elapsed = '0;
							ev_rate          = shift_peak_q;
						end
					end else begin
						if (sh_e < SH_DOWN) begin
							ev_div   = 1'b1;
							ev_from  = shift_peak_q;
							ev_to    = OUT_W'(shift_base_q);
							ev_mul_b = sh_e;
							ev_d     = SH_DOWN;
						end else begin
							ev_shift_active = 1'b0;
							ev_rate         = OUT_W'(shift_base_q);
						end
					end
				end
			end
			OP_REV_START: begin
				if (!rev_active_q) begin
					ev_rev_active  = 1'b1;
					ev_rev_falling = 1'b0;
					ev_rev_elapsed = '0;
					ev_rev_base    = thr_q;
				end
			end
			OP_REV_STOP: begin
				if (rev_active_q) begin
					ev_rev_active  = 1'b0;
					ev_rev_falling = 1'b1;
					ev_rev_elapsed = '0;
				end
			end
			OP_GEAR_UP, OP_GEAR_DOWN: begin
				if (shift_ok && (((op_q == OP_GEAR_UP) && (gear_q < cfg.top_gear)) ||
						((op_q == OP_GEAR_DOWN) && (gear_q > GEAR_W'(1))))) begin
					ev_gear          = (op_q == OP_GEAR_UP) ? gear_q + 1'b1 : gear_q - 1'b1;
					ev_shift_base    = thr_q;
					ev_shift_elapsed = '0;
					ev_shift_second  = 1'b0;
					ev_shift_active  = 1'b1;
					// peak goes through the divider as thr * 13 / 10
					ev_div           = 1'b1;
					ev_peak          = 1'b1;
					ev_to            = OUT_W'(thr_q);
					ev_mul_b         = PEAK_MUL;
					ev_d             = PEAK_DIV;
				end
			end
			default: begin
			end
		endcase
	end

	// restoring divider step
	assign trial    = {rem_q, quo_q[PROD_W-1]};
	assign trial_ge = (trial >= {1'b0, div_d_q});

	// architectural state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_active_q    <= 1'b0;
			rev_falling_q   <= 1'b0;
			rev_elapsed_q   <= '0;
			rev_base_q      <= '0;
			shift_active_q  <= 1'b0;
			shift_second_q  <= 1'b0;
			shift_elapsed_q <= '0;
			shift_base_q    <= '0;
			shift_peak_q    <= '0;
			gear_q          <= GEAR_W'(1);
		end else begin
			if (ctrl.act == ACT_EVAL) begin
				rev_active_q    <= ev_rev_active;
				rev_falling_q   <= ev_rev_falling;
				rev_elapsed_q   <= ev_rev_elapsed;
				rev_base_q      <= ev_rev_base;
				shift_active_q  <= ev_shift_active;
				shift_second_q  <= ev_shift_second;
				shift_elapsed_q <= ev_shift_elapsed;
				shift_base_q    <= ev_shift_base;
				gear_q          <= ev_gear;
			end
			if ((ctrl.act == ACT_FIN) && peak_mode_q) begin
				shift_peak_q <= quo_q[OUT_W-1:0];
			end
		end
	end

	// working datapath: latch, set up, multiply, divide, finish
	always_ff @(posedge clk) begin
		unique case (ctrl.act)
			ACT_WAIT: begin
				if (stat.accept) begin
					op_q  <= item.operation;
					thr_q <= item.throttle_rate;
				end
			end
			ACT_EVAL: begin
				rate_q      <= ev_rate;
				upd_q       <= ev_upd;
				peak_mode_q <= ev_peak;
				from_q      <= ev_from;
				neg_q       <= (ev_to < ev_from);
				mag_q       <= (ev_to < ev_from) ? ev_from - ev_to : ev_to - ev_from;
				mul_b_q     <= ev_mul_b;
				div_d_q     <= ev_d;
			end
			ACT_MUL: begin
				quo_q <= PROD_W'(mag_q) * PROD_W'(mul_b_q);
				rem_q <= '0;
				cnt_q <= '0;
			end
			ACT_DIV: begin
				rem_q <= trial_ge ? REM_W'(trial - {1'b0, div_d_q}) : trial[REM_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], trial_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			ACT_FIN: begin
				if (!peak_mode_q) begin
					rate_q <= neg_q ? from_q - quo_q[OUT_W-1:0] : from_q + quo_q[OUT_W-1:0];
				end
			end
			ACT_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctrl.act == ACT_OUT) && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if ((ctrl.act == ACT_OUT) && !out_busy) begin
			out_rate_q      <= upd_q ? rate_q : '0;
			out_upd_q       <= upd_q;
			out_gear_q      <= gear_q;
			out_busy_flag_q <= rev_active_q || rev_falling_q || shift_active_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.sample_rate = out_rate_q;
	assign result.rate_update = out_upd_q;
	assign result.gear_now    = out_gear_q;
	assign result.ramp_busy   = out_busy_flag_q;

	// checks
	`PRRC_ASSERT_ALWAYS(a_rev_excl, !(rev_active_q && rev_falling_q), "rev up and down both set")
	`PRRC_ASSERT_ALWAYS(a_gear_nonzero, gear_q != '0, "gear dropped to zero")
	`PRRC_ASSERT_IMPL(a_div_count, ctrl.act == ACT_DIV, cnt_q < CNT_W'(DIV_STEPS), "divider overran")
	`PRRC_ASSERT_NEXT(a_accept_eval, stat.accept, ctrl.act == ACT_EVAL, "accept not followed by eval")

endmodule

>>> verif/playback_rate_ramp_controller_top_tb.sv
// ---------------------------------------------------------------------------
// playback_rate_ramp_controller_top_tb
// Drives rev, gear and tick events into the rate ramp controller, predicts
// every result transaction with an envelope model kept in step with the
// configuration registers, and compares each result field by field.
// Directed scenarios cover idle events, rev ramps, shifts and elapsed
// saturation. Output backpressure is also covered, followed by random
// well-formed event sequences under several register settings.
// ---------------------------------------------------------------------------
module playback_rate_ramp_controller_top_tb;
	import prrc_pkg::*;

	localparam int SHIFT_UP_MS   = 150;
	localparam int SHIFT_DOWN_MS = 200;
	localparam int RATE_MAX      = (1 << RATE_W) - 1;
	localparam int MS_MAX        = (1 << MS_W) - 1;
	localparam int GEAR_MAX      = (1 << GEAR_W) - 1;
	localparam int STALL_LIMIT   = 2000;
	localparam int TAIL_CYCLES   = 60;
	localparam int HOLDOFF_LEN   = 400;
	localparam int RANDOM_ITEMS  = 1750;
	localparam int RANDOM_PHASES = 6;

	// codes the block ignores
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_GEAR_DOWN + 1'b1;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = '1;

	typedef struct packed {
		logic [OUT_W-1:0]  sample_rate;
		logic              rate_update;
		logic [GEAR_W-1:0] gear_now;
		logic              ramp_busy;
	} rate_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	prrc_in_if  event_ch();
	prrc_out_if rate_ch();

	playback_rate_ramp_controller_top #(
		.SHIFT_UP_MS   (SHIFT_UP_MS),
		.SHIFT_DOWN_MS (SHIFT_DOWN_MS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (event_ch),
		.result  (rate_ch)
	);

	// envelope model: settings
	logic [RATE_W-1:0] set_target;
	logic [MS_W-1:0]   set_up_ms;
	logic [MS_W-1:0]   set_down_ms;
	logic [GEAR_W-1:0] set_top_gear;

	// envelope model: state
	logic              rev_on;
	logic              rev_down;
	logic [MS_W-1:0]   rev_ms;
	logic [RATE_W-1:0] rev_base;
	logic              shift_on;
	logic              shift_back;
	logic [MS_W-1:0]   shift_ms;
	logic [RATE_W-1:0] shift_base;
	logic [OUT_W-1:0]  shift_peak;
	logic [GEAR_W-1:0] gear;

	rate_result_t expected_rates[$];
	int mismatches;
	int items_sent;
	int holdoff_request;
	bit gaps_on;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [RATE_W-1:0] rand_throttle();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return RATE_W'($urandom_range(0, RATE_MAX));
	endfunction

	// linear point between two rates, quotient truncated toward zero
	function automatic logic [OUT_W-1:0] ramp_point(input logic [OUT_W-1:0] from,
		input logic [OUT_W-1:0] to, input logic [MS_W-1:0] e, input logic [MS_W-1:0] d);
		logic [63:0] span;
		if (d == '0)
			return to;
		if (to >= from) begin
			span = (64'(to - from) * 64'(e)) / 64'(d);
			return from + span[OUT_W-1:0];
		end
		span = (64'(from - to) * 64'(e)) / 64'(d);
		return from - span[OUT_W-1:0];
	endfunction

	function automatic logic [MS_W-1:0] bump_ms(input logic [MS_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic void begin_shift(input logic [RATE_W-1:0] thr);
		shift_base = thr;
		shift_peak = OUT_W'((32'(thr) * 32'(PEAK_MUL)) / 32'(PEAK_DIV));
		shift_ms   = '0;
		shift_back = 1'b0;
		shift_on   = 1'b1;
	endfunction

	// one event applied to the envelope model
	function automatic rate_result_t advance_envelope(input logic [OP_W-1:0] op,
		input logic [RATE_W-1:0] thr);
		rate_result_t r;
		logic [OUT_W-1:0] rate;
		logic upd;
		rate = '0;
		upd = 1'b0;
		case (op)
			OP_TICK: begin
				if (rev_on || rev_down)
					rev_ms = bump_ms(rev_ms);
				if (shift_on)
					shift_ms = bump_ms(shift_ms);
				// rev ramp wins over a running shift
				if (rev_on) begin
					upd = 1'b1;
					if (rev_ms >= set_up_ms)
						rate = set_target;
					else
						rate = ramp_point(rev_base, set_target, rev_ms, set_up_ms);
				end else if (rev_down) begin
					upd = 1'b1;
					if (rev_ms < set_down_ms)
						rate = ramp_point(set_target, rev_base, rev_ms, set_down_ms);
					else begin
						rate = rev_base;
						rev_down = 1'b0;
					end
				end else if (shift_on) begin
					upd = 1'b1;
					if (!shift_back) begin
						if (shift_ms < SHIFT_UP_MS)
							rate = ramp_point(shift_base, shift_peak, shift_ms, MS_W'(SHIFT_UP_MS));
						else begin
							shift_back = 1'b1;
							shift_ms = '0;
							rate = shift_peak;
						end
					end else begin
						if (shift_ms < SHIFT_DOWN_MS)
							rate = ramp_point(shift_peak, shift_base, shift_ms, MS_W'(SHIFT_DOWN_MS));
						else begin
							shift_on = 1'b0;
							rate = shift_base;
						end
					end
				end
			end
			OP_REV_START: begin
				if (!rev_on) begin
					rev_on = 1'b1;
					rev_down = 1'b0;
					rev_ms = '0;
					rev_base = thr;
				end
			end
			OP_REV_STOP: begin
				if (rev_on) begin
					rev_on = 1'b0;
					rev_down = 1'b1;
					rev_ms = '0;
				end
			end
			OP_GEAR_UP: begin
				if (gear < set_top_gear && !shift_on && !rev_on) begin
					gear = gear + 1'b1;
					begin_shift(thr);
				end
			end
			OP_GEAR_DOWN: begin
				if (gear > 1 && !shift_on && !rev_on) begin
					gear = gear - 1'b1;
					begin_shift(thr);
				end
			end
			default: begin
			end
		endcase
		r.sample_rate = upd ? rate : '0;
		r.rate_update = upd;
		r.gear_now    = gear;
		r.ramp_busy   = rev_on || rev_down || shift_on;
		return r;
	endfunction

	function automatic logic [31:0] setting_of(input logic [1:0] idx);
		case (idx)
			REG_REV_TARGET: return 32'(set_target);
			REG_REV_UP:     return 32'(set_up_ms);
			REG_REV_DOWN:   return 32'(set_down_ms);
			default:        return 32'(set_top_gear);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t  check failed: %s", $time, msg);
		mismatches++;
	endtask

	// register write followed by a readback
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_REV_TARGET: set_target   = val[RATE_W-1:0];
			REG_REV_UP:     set_up_ms    = val[MS_W-1:0];
			REG_REV_DOWN:   set_down_ms  = val[MS_W-1:0];
			default:        set_top_gear = val[GEAR_W-1:0];
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== setting_of(idx))
			report_mismatch($sformatf("register %0d read %0d, written %0d",
				idx, prdata, setting_of(idx)));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_settings(input int target, input int up_ms, input int down_ms,
		input int top);
		write_reg(REG_REV_TARGET, 32'(target));
		write_reg(REG_REV_UP, 32'(up_ms));
		write_reg(REG_REV_DOWN, 32'(down_ms));
		write_reg(REG_TOP_GEAR, 32'(top));
	endtask

	// one event transaction, expectation queued on acceptance
	task automatic send_event(input logic [OP_W-1:0] op, input logic [RATE_W-1:0] thr);
		int gap;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			event_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		event_ch.valid         <= 1'b1;
		event_ch.operation     <= op;
		event_ch.throttle_rate <= thr;
		@(posedge clk);
		while (!event_ch.ready) @(posedge clk);
		expected_rates.push_back(advance_envelope(op, thr));
		if (op <= OP_GEAR_DOWN)
			items_sent++;
	endtask

	task automatic tick_run(input int n);
		repeat (n) send_event(OP_TICK, rand_throttle());
	endtask

	// sender pauses until every result is back
	task automatic wait_results_done();
		event_ch.valid <= 1'b0;
		while (expected_rates.size() != 0) @(posedge clk);
	endtask

	task automatic test_idle_events();
		send_event(OP_TICK, '0);
		send_event(OP_SPARE_LAST, '1);
		send_event(OP_SPARE_FIRST, RATE_W'(21845));
		send_event(OP_REV_STOP, '1);
		send_event(OP_GEAR_DOWN, '1);
		send_event(OP_TICK, '1);
		wait_results_done();
	endtask

	task automatic test_rev_ramps();
		// upward ramp from zero to full scale
		apply_settings(RATE_MAX, 4, 3, GEAR_MAX);
		send_event(OP_REV_START, '0);
		send_event(OP_REV_START, '1);
		send_event(OP_GEAR_UP, '1);
		tick_run(6);
		send_event(OP_REV_STOP, '0);
		send_event(OP_REV_STOP, '1);
		tick_run(5);
		wait_results_done();
		// zero length ramps finish on the first tick
		apply_settings(0, 0, 0, GEAR_MAX);
		send_event(OP_REV_START, '1);
		send_event(OP_TICK, '0);
		send_event(OP_REV_STOP, '0);
		tick_run(2);
		wait_results_done();
		// downward ramp toward a zero target
		apply_settings(0, 5, 2, GEAR_MAX);
		send_event(OP_REV_START, '1);
		tick_run(6);
		send_event(OP_REV_STOP, '0);
		tick_run(3);
		wait_results_done();
	endtask

	task automatic test_gear_shifts();
		apply_settings(44100, 2, 2, 3);
		// full shift with the largest peak, requests refused meanwhile
		send_event(OP_GEAR_UP, '1);
		send_event(OP_GEAR_UP, '0);
		send_event(OP_GEAR_DOWN, '0);
		tick_run(352);
		send_event(OP_GEAR_UP, '0);
		tick_run(351);
		send_event(OP_GEAR_UP, '1);
		wait_results_done();
		// gear left above a lowered top gear, shift overlapped by a rev
		apply_settings(44100, 2, 2, 1);
		send_event(OP_GEAR_UP, '1);
		send_event(OP_GEAR_DOWN, RATE_W'(12345));
		send_event(OP_REV_START, RATE_W'(1000));
		tick_run(4);
		send_event(OP_REV_STOP, '0);
		tick_run(360);
		// shift started while the rev falls back
		send_event(OP_REV_START, RATE_W'(500));
		send_event(OP_REV_STOP, '0);
		send_event(OP_GEAR_DOWN, RATE_W'(99999));
		tick_run(360);
		send_event(OP_GEAR_DOWN, '1);
		wait_results_done();
	endtask

	task automatic test_output_holdoff();
		apply_settings(100000, 60, 60, 6);
		gaps_on = 1'b0;
		send_event(OP_REV_START, RATE_W'(20000));
		holdoff_request = HOLDOFF_LEN;
		tick_run(24);
		send_event(OP_REV_STOP, '0);
		tick_run(10);
		gaps_on = 1'b1;
		wait_results_done();
	endtask

	task automatic test_elapsed_saturation();
		apply_settings(77777, 2, 5, 6);
		gaps_on = 1'b0;
		send_event(OP_REV_START, RATE_W'(100));
		// past the point where the elapsed count would wrap
		tick_run(MS_MAX + 5);
		send_event(OP_REV_STOP, '0);
		tick_run(6);
		gaps_on = 1'b1;
		wait_results_done();
	endtask

	task automatic random_sequence();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			// rev up, maybe a repeated start, rev down
			send_event(OP_REV_START, rand_throttle());
			tick_run($urandom_range(0, 45));
			if ($urandom_range(0, 3) == 0)
				send_event(OP_REV_START, rand_throttle());
			if ($urandom_range(0, 9) != 0)
				send_event(OP_REV_STOP, rand_throttle());
			tick_run($urandom_range(0, 45));
		end else if (pick < 62) begin
			send_event($urandom_range(0, 1) ? OP_GEAR_UP : OP_GEAR_DOWN, rand_throttle());
			tick_run($urandom_range(1, 60));
		end else if (pick < 67) begin
			tick_run($urandom_range(150, 360));
		end else if (pick < 85) begin
			tick_run($urandom_range(1, 12));
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) send_event(OP_W'($urandom_range(0, int'(OP_SPARE_LAST))), rand_throttle());
		end
	endtask

	task automatic test_random_mix();
		int phase;
		int stop_at;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_results_done();
			case (phase)
				0: apply_settings(0, 1, 1, 1);
				1: apply_settings(RATE_MAX, MS_MAX, MS_MAX, GEAR_MAX);
				default: apply_settings($urandom_range(0, RATE_MAX), $urandom_range(0, 40),
					$urandom_range(0, 40), $urandom_range(1, GEAR_MAX));
			endcase
			gaps_on = (phase != 3);
			stop_at = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
			while (items_sent < stop_at) random_sequence();
		end
		gaps_on = 1'b1;
		wait_results_done();
	endtask

	// result receiver with random stalls and requested hold-offs
	initial begin : result_receiver
		int stall_left;
		stall_left = 0;
		rate_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_request > 0) begin
				stall_left = holdoff_request;
				holdoff_request = 0;
			end else if (stall_left == 0 && gaps_on && $urandom_range(0, 99) < 30)
				stall_left = pick_gap();
			if (stall_left > 0) begin
				stall_left--;
				rate_ch.ready <= 1'b0;
			end else
				rate_ch.ready <= 1'b1;
		end
	end

	// result checker against the oldest expectation
	always @(posedge clk) begin : rate_checker
		rate_result_t want;
		if (arst_n && rate_ch.valid && rate_ch.ready) begin
			if (expected_rates.size() == 0)
				report_mismatch("result transaction with nothing expected");
			else begin
				want = expected_rates.pop_front();
				if (rate_ch.sample_rate !== want.sample_rate)
					report_mismatch($sformatf("sample_rate %0d, expected %0d",
						rate_ch.sample_rate, want.sample_rate));
				if (rate_ch.rate_update !== want.rate_update)
					report_mismatch($sformatf("rate_update %0b, expected %0b",
						rate_ch.rate_update, want.rate_update));
				if (rate_ch.gear_now !== want.gear_now)
					report_mismatch($sformatf("gear_now %0d, expected %0d",
						rate_ch.gear_now, want.gear_now));
				if (rate_ch.ramp_busy !== want.ramp_busy)
					report_mismatch($sformatf("ramp_busy %0b, expected %0b",
						rate_ch.ramp_busy, want.ramp_busy));
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((event_ch.valid && event_ch.ready) || (rate_ch.valid && rate_ch.ready) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("playback_rate_ramp_controller_top: mismatch");
		$finish;
	end

	initial begin : main_sequence
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		event_ch.valid = 1'b0;
		event_ch.operation = OP_TICK;
		event_ch.throttle_rate = '0;
		mismatches = 0;
		items_sent = 0;
		holdoff_request = 0;
		gaps_on = 1'b1;
		// register and state values after reset
		set_target = RATE_W'(44100);
		set_up_ms = MS_W'(1000);
		set_down_ms = MS_W'(1000);
		set_top_gear = GEAR_W'(6);
		rev_on = 1'b0;
		rev_down = 1'b0;
		rev_ms = '0;
		rev_base = '0;
		shift_on = 1'b0;
		shift_back = 1'b0;
		shift_ms = '0;
		shift_base = '0;
		shift_peak = '0;
		gear = GEAR_W'(1);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_events();
		test_rev_ramps();
		test_gear_shifts();
		test_output_holdoff();
		test_elapsed_saturation();
		test_random_mix();
		wait_results_done();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_rates.size() == 0)
			$display("playback_rate_ramp_controller_top: match");
		else
			$display("playback_rate_ramp_controller_top: mismatch");
		$finish;
	end

endmodule
